// File: rtl/core/qsep_pkg.sv
// Shared types, codes and character constants for the quoted-string entry parser.
package qsep_pkg;

   // Default number of tag bytes that the tag buffer can hold.
   localparam int TAG_CAPACITY_DEFAULT = 15;

   // Length of the tag text that clears a pending tag.
   localparam int NO_TR_LEN = 14;

   // Tag text that clears a pending tag when a newline follows it.
   localparam logic [7:0] NO_TR_TEXT [NO_TR_LEN] = '{
      8'h4E, 8'h6F, 8'h20, 8'h74, 8'h72, 8'h61, 8'h6E,
      8'h73, 8'h6C, 8'h61, 8'h74, 8'h69, 8'h6F, 8'h6E
   };

   // Characters that the parser reacts to.
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_BEL    = 8'h07;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_SEVEN  = 8'h37;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;

   // Parser modes, one-hot.
   typedef enum logic [8:0] {
      MODE_LINE     = 9'b000000001,
      MODE_COMMENT  = 9'b000000010,
      MODE_STRING   = 9'b000000100,
      MODE_ESCAPE   = 9'b000001000,
      MODE_OCTAL    = 9'b000010000,
      MODE_TAG      = 9'b000100000,
      MODE_DONE     = 9'b001000000,
      MODE_ERROR    = 9'b010000000,
      MODE_ERROR_NL = 9'b100000000
   } mode_type;

   // Result kinds.
   typedef enum logic [3:0] {
      KIND_NONE        = 4'd0,
      KIND_STR         = 4'd1,
      KIND_TAG         = 4'd2,
      KIND_TAG_END     = 4'd3,
      KIND_DONE        = 4'd4,
      KIND_BLANK       = 4'd5,
      KIND_SYNTAX      = 4'd6,
      KIND_BAD_TAG     = 4'd7,
      KIND_JUNK        = 4'd8,
      KIND_BAD_ESC     = 4'd9,
      KIND_UNEXP_END   = 4'd10,
      KIND_CLEAN_END   = 4'd11,
      KIND_TAG_CLEARED = 4'd12
   } kind_type;

   // One result word.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic [3:0] len;
      logic       last;
   } res_type;

   // ASCII letter or digit.
   function automatic logic is_alnum(input logic [7:0] c);
      is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                 (c >= 8'h61 && c <= 8'h7A);
   endfunction

   // ASCII white space: space, tab, LF, VT, FF, CR.
   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

endpackage

// File: rtl/core/quoted_string_entry_parser.sv
// Top level of the quoted-string entry parser: parse state, tag buffer and result queue.
//
// Takes a text file one byte word per cycle and returns parse results (string bytes, tag
// bytes, entry ends and error reports) in order. Each input word is decoded in the cycle
// it is accepted and gives zero, one or two results, which enter a three-slot result queue;
// rsp_last_of_run marks the final result of a word. A word is accepted whenever the queue
// holds at most one result, so the block takes one word every cycle as long as each word
// gives at most one result and the output side is not stalled; a word that gives two
// results (a closing octal escape, or end of input inside one) stalls the input until the
// queue holds at most one result again. Results are registered in the queue before output.
module quoted_string_entry_parser #(
   parameter int TAG_CAPACITY = qsep_pkg::TAG_CAPACITY_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   input  logic       req_abort_on_blank,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [3:0] rsp_tag_length,
   output logic       rsp_last_of_run
);

   localparam int CountWidth = $clog2(TAG_CAPACITY);

   logic                  accept;
   logic                  room;
   logic                  tag_match;
   logic                  tag_wr_en;
   logic [CountWidth-1:0] tag_count;
   logic [1:0]            res_num;
   logic [1:0]            push_num;
   qsep_pkg::res_type     res0, res1, head;

   // Input handshake.
   assign req_stall = !room;
   assign accept    = req_valid && room;
   assign push_num  = accept ? res_num : 2'd0;

   qsep_parse #(
      .TAG_CAPACITY (TAG_CAPACITY)
   ) u_parse (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .in_byte        (req_in_byte),
      .end_of_input   (req_end_of_input),
      .abort_on_blank (req_abort_on_blank),
      .tag_match      (tag_match),
      .tag_count      (tag_count),
      .tag_wr_en      (tag_wr_en),
      .res0           (res0),
      .res1           (res1),
      .res_num        (res_num)
   );

   qsep_tag_store #(
      .TAG_CAPACITY (TAG_CAPACITY)
   ) u_tag_store (
      .clock     (clock),
      .wr_en     (tag_wr_en),
      .tag_count (tag_count),
      .wr_data   (req_in_byte),
      .tag_match (tag_match)
   );

   qsep_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push_num  (push_num),
      .push0     (res0),
      .push1     (res1),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .head      (head),
      .room      (room)
   );

   // Result word fields.
   assign rsp_kind        = head.kind;
   assign rsp_out_byte    = head.data;
   assign rsp_tag_length  = head.len;
   assign rsp_last_of_run = head.last;

endmodule

// File: rtl/core/qsep_tag_store.sv
// Tag byte buffer with the compare against the tag-clearing text.
module qsep_tag_store #(
   parameter int TAG_CAPACITY = qsep_pkg::TAG_CAPACITY_DEFAULT,
   localparam int CountWidth = $clog2(TAG_CAPACITY)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [CountWidth-1:0] tag_count,
   input  logic [7:0]            wr_data,
   output logic                  tag_match
);

   logic [7:0] bytes_ff [TAG_CAPACITY];
   logic       text_eq;

   // Tag bytes are written at the current count; an unwritten entry never decides the match.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bytes_ff[tag_count] <= wr_data;
      end
   end

   // The first entries must spell the clearing text exactly.
   always_comb begin
      text_eq = 1'b1;
      for (int k = 0; k < qsep_pkg::NO_TR_LEN; k++) begin
         if (bytes_ff[k] != qsep_pkg::NO_TR_TEXT[k]) begin
            text_eq = 1'b0;
         end
      end
   end

   assign tag_match = (tag_count == CountWidth'(qsep_pkg::NO_TR_LEN)) && text_eq;

endmodule

// File: rtl/core/qsep_parse.sv
// Parse state registers and the per-word decode that yields up to two results.
module qsep_parse #(
   parameter int TAG_CAPACITY = qsep_pkg::TAG_CAPACITY_DEFAULT,
   localparam int CountWidth = $clog2(TAG_CAPACITY)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              in_byte,
   input  logic                    end_of_input,
   input  logic                    abort_on_blank,
   input  logic                    tag_match,
   output logic [CountWidth-1:0]   tag_count,
   output logic                    tag_wr_en,
   output qsep_pkg::res_type       res0,
   output qsep_pkg::res_type       res1,
   output logic [1:0]              res_num
);

   qsep_pkg::mode_type    mode_ff, mode_in, cur_mode;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [7:0]            octal_ff, octal_in;
   logic                  handle;
   logic                  pre_valid;
   logic                  main_valid;
   qsep_pkg::kind_type    main_kind;
   logic [7:0]            main_data;
   logic [3:0]            main_len;
   logic                  wr_req;
   logic                  is_digit;

   assign is_digit = (in_byte >= qsep_pkg::CH_ZERO) && (in_byte <= qsep_pkg::CH_SEVEN);

   // Next-state and result decode for one word.
   always_comb begin
      mode_in    = mode_ff;
      count_in   = count_ff;
      octal_in   = octal_ff;
      cur_mode   = mode_ff;
      handle     = 1'b0;
      pre_valid  = 1'b0;
      main_valid = 1'b0;
      main_kind  = qsep_pkg::KIND_NONE;
      main_data  = 8'h00;
      main_len   = 4'h0;
      wr_req     = 1'b0;

      if (end_of_input) begin
         // End of file flushes a pending octal byte and closes the entry.
         pre_valid  = (mode_ff == qsep_pkg::MODE_OCTAL);
         main_valid = 1'b1;
         main_kind  = (mode_ff == qsep_pkg::MODE_LINE) ? qsep_pkg::KIND_CLEAN_END :
                                                         qsep_pkg::KIND_UNEXP_END;
         mode_in    = qsep_pkg::MODE_LINE;
         count_in   = '0;
         octal_in   = 8'h00;
      end else begin
         handle = 1'b1;
         // Octal digits accumulate; any other byte emits the value and is reparsed.
         if (mode_ff == qsep_pkg::MODE_OCTAL) begin
            if (is_digit) begin
               octal_in = {octal_ff[4:0], in_byte[2:0]};
               handle   = 1'b0;
            end else begin
               pre_valid = 1'b1;
               octal_in  = 8'h00;
               cur_mode  = qsep_pkg::MODE_STRING;
               mode_in   = qsep_pkg::MODE_STRING;
            end
         end

         // Carriage returns are dropped everywhere else.
         if (handle && in_byte != qsep_pkg::CH_CR) begin
            unique case (cur_mode)
               qsep_pkg::MODE_LINE: begin
                  if (in_byte == qsep_pkg::CH_HASH) begin
                     mode_in = qsep_pkg::MODE_COMMENT;
                  end else if (in_byte == qsep_pkg::CH_QUOTE) begin
                     mode_in = qsep_pkg::MODE_STRING;
                  end else if (in_byte == qsep_pkg::CH_LF && abort_on_blank) begin
                     mode_in    = qsep_pkg::MODE_LINE;
                     count_in   = '0;
                     octal_in   = 8'h00;
                     main_valid = 1'b1;
                     main_kind  = qsep_pkg::KIND_BLANK;
                  end else if (count_ff == '0 && qsep_pkg::is_alnum(in_byte)) begin
                     wr_req     = 1'b1;
                     count_in   = CountWidth'(1);
                     mode_in    = qsep_pkg::MODE_TAG;
                     main_valid = 1'b1;
                     main_kind  = qsep_pkg::KIND_TAG;
                     main_data  = in_byte;
                  end else if (!qsep_pkg::is_space(in_byte)) begin
                     mode_in    = qsep_pkg::MODE_ERROR;
                     main_valid = 1'b1;
                     main_kind  = qsep_pkg::KIND_SYNTAX;
                  end
               end
               qsep_pkg::MODE_COMMENT: begin
                  if (in_byte == qsep_pkg::CH_LF) begin
                     mode_in = qsep_pkg::MODE_LINE;
                  end
               end
               qsep_pkg::MODE_STRING: begin
                  if (in_byte == qsep_pkg::CH_BSLASH) begin
                     mode_in = qsep_pkg::MODE_ESCAPE;
                  end else if (in_byte == qsep_pkg::CH_QUOTE) begin
                     mode_in = qsep_pkg::MODE_DONE;
                  end else begin
                     main_valid = 1'b1;
                     main_kind  = qsep_pkg::KIND_STR;
                     main_data  = in_byte;
                  end
               end
               qsep_pkg::MODE_ESCAPE: begin
                  mode_in    = qsep_pkg::MODE_STRING;
                  main_valid = 1'b1;
                  main_kind  = qsep_pkg::KIND_STR;
                  unique case (in_byte) inside
                     qsep_pkg::CH_LOW_N: main_data = qsep_pkg::CH_LF;
                     qsep_pkg::CH_LOW_R: main_data = qsep_pkg::CH_CR;
                     qsep_pkg::CH_LOW_T: main_data = qsep_pkg::CH_TAB;
                     qsep_pkg::CH_LOW_E: main_data = qsep_pkg::CH_ESC;
                     qsep_pkg::CH_LOW_A: main_data = qsep_pkg::CH_BEL;
                     qsep_pkg::CH_HASH, qsep_pkg::CH_QUOTE, qsep_pkg::CH_BSLASH: begin
                        main_data = in_byte;
                     end
                     qsep_pkg::CH_LF: begin
                        // Line continuation gives nothing.
                        main_valid = 1'b0;
                     end
                     qsep_pkg::CH_ZERO: begin
                        main_valid = 1'b0;
                        octal_in   = 8'h00;
                        mode_in    = qsep_pkg::MODE_OCTAL;
                     end
                     default: begin
                        main_kind = qsep_pkg::KIND_BAD_ESC;
                        main_data = in_byte;
                     end
                  endcase
               end
               qsep_pkg::MODE_TAG: begin
                  main_valid = 1'b1;
                  if (in_byte == qsep_pkg::CH_COLON) begin
                     mode_in   = qsep_pkg::MODE_LINE;
                     main_kind = qsep_pkg::KIND_TAG_END;
                  end else if (in_byte == qsep_pkg::CH_LF && tag_match) begin
                     count_in  = '0;
                     mode_in   = qsep_pkg::MODE_LINE;
                     main_kind = qsep_pkg::KIND_TAG_CLEARED;
                  end else begin
                     wr_req = 1'b1;
                     // A full buffer or a stray character ends the tag in error.
                     if (count_ff == CountWidth'(TAG_CAPACITY - 1) ||
                         (!qsep_pkg::is_alnum(in_byte) && !qsep_pkg::is_space(in_byte))) begin
                        count_in  = '0;
                        mode_in   = qsep_pkg::MODE_ERROR;
                        main_kind = qsep_pkg::KIND_BAD_TAG;
                     end else begin
                        count_in  = count_ff + 1'b1;
                        main_kind = qsep_pkg::KIND_TAG;
                        main_data = in_byte;
                     end
                  end
               end
               qsep_pkg::MODE_DONE: begin
                  if (in_byte == qsep_pkg::CH_LF) begin
                     mode_in    = qsep_pkg::MODE_LINE;
                     count_in   = '0;
                     octal_in   = 8'h00;
                     main_valid = 1'b1;
                     main_kind  = qsep_pkg::KIND_DONE;
                     main_len   = (32'(count_ff) > 32'd15) ? 4'hF : 4'(count_ff);
                  end else if (!qsep_pkg::is_space(in_byte)) begin
                     mode_in    = qsep_pkg::MODE_ERROR;
                     main_valid = 1'b1;
                     main_kind  = qsep_pkg::KIND_JUNK;
                  end
               end
               qsep_pkg::MODE_ERROR: begin
                  if (in_byte == qsep_pkg::CH_LF) begin
                     mode_in = qsep_pkg::MODE_ERROR_NL;
                  end
               end
               qsep_pkg::MODE_ERROR_NL: begin
                  mode_in = (in_byte == qsep_pkg::CH_LF) ? qsep_pkg::MODE_LINE :
                                                           qsep_pkg::MODE_ERROR;
               end
               default: begin
                  mode_in = qsep_pkg::MODE_LINE;
               end
            endcase
         end
      end
   end

   // Pack the results in order; the octal byte always comes first.
   always_comb begin
      res0      = '0;
      res1      = '0;
      res0.kind = qsep_pkg::KIND_NONE;
      res1.kind = qsep_pkg::KIND_NONE;
      if (pre_valid) begin
         res0.kind = qsep_pkg::KIND_STR;
         res0.data = octal_ff;
         res0.last = !main_valid;
         res1.kind = main_kind;
         res1.data = main_data;
         res1.len  = main_len;
         res1.last = 1'b1;
      end else begin
         res0.kind = main_kind;
         res0.data = main_data;
         res0.len  = main_len;
         res0.last = 1'b1;
      end
      res_num = {1'b0, pre_valid} + {1'b0, main_valid};
   end

   // Parse state updates on each accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= qsep_pkg::MODE_LINE;
         count_ff <= '0;
         octal_ff <= 8'h00;
      end else if (accept) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         octal_ff <= octal_in;
      end
   end

   assign tag_count = count_ff;
   assign tag_wr_en = accept && wr_req;

endmodule

// File: rtl/core/qsep_rsp_queue.sv
// Three-slot result queue: up to two results in a cycle, one out unless stalled.
module qsep_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_num,
   input  qsep_pkg::res_type push0,
   input  qsep_pkg::res_type push1,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output qsep_pkg::res_type head,
   output logic              room
);

   qsep_pkg::res_type slot_ff [3];
   qsep_pkg::res_type slot_in [3];
   qsep_pkg::res_type shifted [3];
   logic [1:0]        count_ff, count_in;
   logic [1:0]        base;
   logic              pop;

   assign pop       = (count_ff != 2'd0) && !rsp_stall;
   assign base      = count_ff - {1'b0, pop};
   assign rsp_valid = (count_ff != 2'd0);
   assign head      = slot_ff[0];
   // Two free slots guarantee space for the largest result pair.
   assign room      = (count_ff <= 2'd1);

   // Shift out the taken result, then append the new ones behind the rest.
   always_comb begin
      shifted[0] = pop ? slot_ff[1] : slot_ff[0];
      shifted[1] = pop ? slot_ff[2] : slot_ff[1];
      shifted[2] = slot_ff[2];
      for (int i = 0; i < 3; i++) begin
         slot_in[i] = shifted[i];
         if (push_num != 2'd0 && base == 2'(i)) begin
            slot_in[i] = push0;
         end
         if (push_num == 2'd2 && base + 2'd1 == 2'(i)) begin
            slot_in[i] = push1;
         end
      end
      count_in = base + push_num;
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   // Fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/core/qsep_checker.sv
// Port-level checks for the quoted-string entry parser, bound to the top level.
module qsep_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic [3:0] rsp_tag_length,
   input logic       rsp_last_of_run
);

   // No result is offered right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte) &&
         $stable(rsp_tag_length) && $stable(rsp_last_of_run))
      else $error("stalled result word changed");

   // Only a string-done result carries a tag length.
   a_len_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != qsep_pkg::KIND_DONE |-> rsp_tag_length == 4'd0)
      else $error("tag length on a result other than string done");

   // A data byte appears only with string, tag or bad-escape results.
   a_byte_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_byte != 8'h00 |->
         rsp_kind == qsep_pkg::KIND_STR || rsp_kind == qsep_pkg::KIND_TAG ||
         rsp_kind == qsep_pkg::KIND_BAD_ESC)
      else $error("data byte on a result kind without one");

endmodule

bind quoted_string_entry_parser qsep_checker u_qsep_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_kind        (rsp_kind),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_tag_length  (rsp_tag_length),
   .rsp_last_of_run (rsp_last_of_run)
);
